// ----- rtl/glb_pkg.sv -----
package glb_pkg;

	localparam int LINE_GLYPHS = 256;
	localparam int INDEX_BITS  = 16;

	// Move of one glyph: 20-bit advance plus 17-bit signed kern.
	localparam int MOVE_W = 22;
	// Running width of a line, kept exact.
	localparam int RW_W   = 36;
	// Alignment arithmetic.
	localparam int AL_W   = 40;

	localparam logic [1:0] REG_WRAP_WIDTH = 2'd0;
	localparam logic [1:0] REG_ALIGN_MODE = 2'd1;

	localparam logic [1:0] ALIGN_CENTER = 2'd1;
	localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

	typedef struct packed {
		logic signed [MOVE_W-1:0] move;
		logic                     space;
		logic signed [7:0]        bear;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [15:0]            start;
		logic [15:0]            stop;
		logic signed [7:0]      bear;
		logic signed [RW_W-1:0] width;
		logic                   last;
	} line_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_EMIT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_PREV_RD,
		S_PREV_CHK,
		S_CALC,
		S_COPY_RD,
		S_COPY_WR,
		S_TAIL,
		S_FINISH,
		S_LAST
	} state_t;

	typedef enum logic [1:0] {
		ACT_NEWLINE,
		ACT_BEGIN,
		ACT_DROP,
		ACT_WRAP
	} act_t;

	function automatic logic signed [RW_W-1:0] bear64(input logic signed [7:0] b);
		bear64 = {{(RW_W-14){b[7]}}, b, 6'b0};
	endfunction

	function automatic logic signed [RW_W-1:0] move_ext(input logic signed [MOVE_W-1:0] m);
		move_ext = {{(RW_W-MOVE_W){m[MOVE_W-1]}}, m};
	endfunction

endpackage

// ----- rtl/greedy_line_breaker_top.sv -----
// Channel   Handshake               Payload
// in        in_valid / in_stall     advance, kern, bearing, is_space, is_newline,
//                                   next_is_space, last_glyph
// out       out_valid / out_stall   line_start, line_end, x_offset, line_width, last_line
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A glyph that stays on its line goes through accept, decide with the line
// store write, and finish. Each emitted line adds the emit step
// that hands it to the output register.
// A soft wrap walks the line store: it reads and checks each glyph scanned back to the
// space, then the glyph before it, then reads and writes each glyph moved to the store start.
// The line store has one read and one write port; that port sets the soft wrap length.
// Reset clears all line state at once; the line store needs no clearing.
// A stalled output holds the sequencer at its emit or last-line step; input is taken
// again once the line is in the output register.
module greedy_line_breaker_top #(
	parameter int LINE_GLYPHS = glb_pkg::LINE_GLYPHS,
	parameter int INDEX_BITS  = glb_pkg::INDEX_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        advance,
	input  logic signed [16:0] kern,
	input  logic signed [7:0]  bearing,
	input  logic               is_space,
	input  logic               is_newline,
	input  logic               next_is_space,
	input  logic               last_glyph,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        line_start,
	output logic [15:0]        line_end,
	output logic signed [23:0] x_offset,
	output logic [23:0]        line_width,
	output logic               last_line,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW = $clog2(LINE_GLYPHS);

	logic [15:0]      wrap_width_q;
	logic [1:0]       align_mode_q;

	logic             req_valid;
	logic             req_ready;
	glb_pkg::line_t   req;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	glb_pkg::entry_t  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	glb_pkg::entry_t  ram_rdata;
	logic [glb_pkg::ENTRY_W-1:0] ram_rdata_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= '0;
			align_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				glb_pkg::REG_WRAP_WIDTH: wrap_width_q <= cfg_data;
				glb_pkg::REG_ALIGN_MODE: align_mode_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	glb_seq #(
		.LINE_GLYPHS(LINE_GLYPHS),
		.INDEX_BITS (INDEX_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.advance      (advance),
		.kern         (kern),
		.bearing      (bearing),
		.is_space     (is_space),
		.is_newline   (is_newline),
		.next_is_space(next_is_space),
		.last_glyph   (last_glyph),
		.wrap_width   (wrap_width_q),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	glb_ram #(
		.WIDTH(glb_pkg::ENTRY_W),
		.DEPTH(LINE_GLYPHS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = glb_pkg::entry_t'(ram_rdata_raw);

	glb_align u_align (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wrap_width(wrap_width_q),
		.align_mode(align_mode_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.line_start(line_start),
		.line_end  (line_end),
		.x_offset  (x_offset),
		.line_width(line_width),
		.last_line (last_line)
	);

endmodule

// ----- rtl/glb_ram.sv -----
module glb_ram #(
	parameter int WIDTH = glb_pkg::ENTRY_W,
	parameter int DEPTH = glb_pkg::LINE_GLYPHS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/glb_align.sv -----
module glb_align (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  glb_pkg::line_t        req,
	input  logic [15:0]           wrap_width,
	input  logic [1:0]            align_mode,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           line_start,
	output logic [15:0]           line_end,
	output logic signed [23:0]    x_offset,
	output logic [23:0]           line_width,
	output logic                  last_line
);

	localparam int AW = glb_pkg::AL_W;

	logic signed [AW-1:0] wrap_s;
	logic signed [AW-1:0] width_s;
	logic signed [AW-1:0] diff;
	logic signed [AW-1:0] half;
	logic signed [AW-1:0] x_s;
	logic signed [AW-1:0] w_s;
	logic signed [23:0]   x_sat;
	logic [23:0]          w_sat;

	logic                 valid_q;
	logic [15:0]          start_q;
	logic [15:0]          end_q;
	logic signed [23:0]   x_q;
	logic [23:0]          w_q;
	logic                 last_q;

	assign wrap_s  = AW'({wrap_width, 6'b0});
	assign width_s = AW'(req.width);
	assign diff    = wrap_s - width_s;
	assign half    = diff >>> 1;

	always_comb begin
		x_s = -AW'(req.bear) * AW'(64);
		w_s = width_s;
		if (align_mode == glb_pkg::ALIGN_CENTER) begin
			x_s = x_s + half;
			w_s = width_s + half;
		end else if (align_mode == glb_pkg::ALIGN_RIGHT) begin
			x_s = x_s + diff;
			w_s = wrap_s;
		end
		if (x_s > AW'(8388607)) begin
			x_sat = 24'sh7FFFFF;
		end else if (x_s < -AW'(8388608)) begin
			x_sat = 24'sh800000;
		end else begin
			x_sat = x_s[23:0];
		end
		if (w_s < 0) begin
			w_sat = '0;
		end else if (w_s > AW'(16777215)) begin
			w_sat = '1;
		end else begin
			w_sat = w_s[23:0];
		end
	end

	assign req_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_ready) begin
			valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			start_q <= req.start;
			end_q   <= req.stop;
			x_q     <= x_sat;
			w_q     <= w_sat;
			last_q  <= req.last;
		end
	end

	assign out_valid  = valid_q;
	assign line_start = start_q;
	assign line_end   = end_q;
	assign x_offset   = x_q;
	assign line_width = w_q;
	assign last_line  = last_q;

endmodule

// ----- rtl/glb_seq.sv -----
module glb_seq #(
	parameter int LINE_GLYPHS = glb_pkg::LINE_GLYPHS,
	parameter int INDEX_BITS  = glb_pkg::INDEX_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [19:0]                    advance,
	input  logic signed [16:0]             kern,
	input  logic signed [7:0]              bearing,
	input  logic                           is_space,
	input  logic                           is_newline,
	input  logic                           next_is_space,
	input  logic                           last_glyph,
	input  logic [15:0]                    wrap_width,
	output logic                           req_valid,
	input  logic                           req_ready,
	output glb_pkg::line_t                 req,
	output logic                           ram_we,
	output logic [$clog2(LINE_GLYPHS)-1:0] ram_waddr,
	output glb_pkg::entry_t                ram_wdata,
	output logic [$clog2(LINE_GLYPHS)-1:0] ram_raddr,
	input  glb_pkg::entry_t                ram_rdata
);

	localparam int AW    = $clog2(LINE_GLYPHS);
	localparam int CNT_W = $clog2(LINE_GLYPHS + 1);
	localparam int RW_W  = glb_pkg::RW_W;
	localparam int MW    = glb_pkg::MOVE_W;

	glb_pkg::state_t state_q, state_d;
	glb_pkg::act_t   act_q, act_d;

	// Current item.
	logic signed [MW-1:0]   mv_q;
	logic signed [7:0]      bear_q;
	logic                   sp_q;
	logic                   nl_q;
	logic                   nsp_q;
	logic                   last_q;

	// Line state.
	logic signed [RW_W-1:0] rw_q;
	logic [INDEX_BITS-1:0]  lb_q;
	logic [INDEX_BITS-1:0]  pos_q;
	logic signed [7:0]      fb_q;
	logic                   seen_q;
	logic                   prev_q;
	logic                   fresh_q;
	logic [CNT_W-1:0]       cnt_q;

	// Soft wrap work registers.
	logic [AW-1:0]          j_q;
	logic [AW-1:0]          s_q;
	logic signed [RW_W-1:0] suf_q;
	logic signed [MW-1:0]   ms_q;
	logic                   drop_q;
	logic signed [RW_W-1:0] thisw_q;
	logic [CNT_W-1:0]       stop_q;
	logic [CNT_W-1:0]       keep_q;
	logic [CNT_W-1:0]       k_q;

	logic                   accept;
	logic signed [MW-1:0]   mv_in;
	logic signed [RW_W-1:0] wrap_s;
	logic                   ovf;
	logic                   isolated;
	logic                   full;
	glb_pkg::entry_t        cur;
	logic signed [7:0]      fb_tail;

	assign accept   = in_valid && !in_stall;
	assign mv_in    = $signed({2'b00, advance})
		+ (last_glyph ? '0 : {{(MW-17){kern[16]}}, kern});
	assign wrap_s   = RW_W'({wrap_width, 6'b0});
	assign ovf      = (rw_q + glb_pkg::move_ext(mv_q)) > wrap_s;
	assign full     = cnt_q == CNT_W'(LINE_GLYPHS);
	assign isolated = (cnt_q == '0 || !prev_q) && (last_q || !nsp_q);
	assign cur      = '{move: mv_q, space: sp_q, bear: bear_q};
	assign fb_tail  = (keep_q == '0) ? bear_q : fb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= glb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		act_d     = act_q;
		in_stall  = 1'b1;
		req_valid = 1'b0;
		req       = '{start: 16'(lb_q), stop: 16'(pos_q), bear: fb_q,
			width: rw_q, last: 1'b0};
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = cur;
		ram_raddr = j_q;
		unique case (state_q)
			glb_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = glb_pkg::S_DECIDE;
				end
			end
			glb_pkg::S_DECIDE: begin
				state_d = glb_pkg::S_EMIT;
				if (nl_q) begin
					act_d = glb_pkg::ACT_NEWLINE;
				end else if (full) begin
					act_d = glb_pkg::ACT_BEGIN;
				end else if (ovf) begin
					if (sp_q) begin
						act_d = isolated ? glb_pkg::ACT_DROP : glb_pkg::ACT_BEGIN;
					end else if (!seen_q) begin
						act_d = glb_pkg::ACT_BEGIN;
					end else begin
						act_d   = glb_pkg::ACT_WRAP;
						state_d = glb_pkg::S_SCAN_RD;
					end
				end else begin
					ram_we  = 1'b1;
					state_d = glb_pkg::S_FINISH;
				end
			end
			glb_pkg::S_SCAN_RD: begin
				state_d = glb_pkg::S_SCAN_CHK;
			end
			glb_pkg::S_SCAN_CHK: begin
				if (ram_rdata.space || j_q == '0) begin
					state_d = (j_q == '0) ? glb_pkg::S_CALC : glb_pkg::S_PREV_RD;
				end else begin
					state_d = glb_pkg::S_SCAN_RD;
				end
			end
			glb_pkg::S_PREV_RD: begin
				ram_raddr = s_q - AW'(1);
				state_d   = glb_pkg::S_PREV_CHK;
			end
			glb_pkg::S_PREV_CHK: begin
				state_d = glb_pkg::S_CALC;
			end
			glb_pkg::S_CALC: begin
				state_d = glb_pkg::S_EMIT;
			end
			glb_pkg::S_EMIT: begin
				req_valid = 1'b1;
				if (act_q == glb_pkg::ACT_WRAP) begin
					req.stop  = 16'(lb_q + INDEX_BITS'(stop_q));
					req.width = thisw_q;
				end
				if (req_ready) begin
					unique case (act_q)
						glb_pkg::ACT_BEGIN: begin
							ram_we    = 1'b1;
							ram_waddr = '0;
							state_d   = glb_pkg::S_FINISH;
						end
						glb_pkg::ACT_WRAP: begin
							state_d = (keep_q == '0) ? glb_pkg::S_TAIL : glb_pkg::S_COPY_RD;
						end
						default: begin
							state_d = glb_pkg::S_FINISH;
						end
					endcase
				end
			end
			glb_pkg::S_COPY_RD: begin
				ram_raddr = AW'(CNT_W'(s_q) + CNT_W'(1) + k_q);
				state_d   = glb_pkg::S_COPY_WR;
			end
			glb_pkg::S_COPY_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[AW-1:0];
				ram_wdata = ram_rdata;
				state_d   = (k_q + CNT_W'(1) == keep_q) ? glb_pkg::S_TAIL : glb_pkg::S_COPY_RD;
			end
			glb_pkg::S_TAIL: begin
				ram_we    = 1'b1;
				ram_waddr = keep_q[AW-1:0];
				state_d   = glb_pkg::S_FINISH;
			end
			glb_pkg::S_FINISH: begin
				state_d = last_q ? glb_pkg::S_LAST : glb_pkg::S_IDLE;
			end
			glb_pkg::S_LAST: begin
				req_valid = 1'b1;
				req.stop  = 16'(pos_q);
				req.last  = 1'b1;
				if (fresh_q) begin
					req.start = 16'(pos_q);
					req.bear  = '0;
					req.width = '0;
				end
				if (req_ready) begin
					state_d = glb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = glb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mv_q   <= mv_in;
			bear_q <= bearing;
			sp_q   <= is_space && !is_newline;
			nl_q   <= is_newline;
			nsp_q  <= next_is_space;
			last_q <= last_glyph;
		end
		case (state_q)
			glb_pkg::S_DECIDE: begin
				j_q    <= AW'(cnt_q - CNT_W'(1));
				suf_q  <= '0;
				drop_q <= 1'b0;
			end
			glb_pkg::S_SCAN_CHK: begin
				if (ram_rdata.space || j_q == '0) begin
					s_q  <= j_q;
					ms_q <= ram_rdata.move;
					if (j_q == '0) begin
						drop_q <= 1'b1;
					end
				end else begin
					suf_q <= suf_q + glb_pkg::move_ext(ram_rdata.move);
					j_q   <= j_q - AW'(1);
				end
			end
			glb_pkg::S_PREV_CHK: begin
				drop_q <= !ram_rdata.space;
			end
			glb_pkg::S_CALC: begin
				// Dropping the space at the break removes its move as well.
				thisw_q <= rw_q - suf_q - (drop_q ? glb_pkg::move_ext(ms_q) : '0);
				stop_q  <= drop_q ? CNT_W'(s_q) : CNT_W'(s_q) + CNT_W'(1);
				keep_q  <= cnt_q - CNT_W'(s_q) - CNT_W'(1);
				k_q     <= '0;
			end
			glb_pkg::S_COPY_WR: begin
				k_q <= k_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= glb_pkg::ACT_NEWLINE;
			rw_q    <= '0;
			lb_q    <= '0;
			pos_q   <= '0;
			fb_q    <= '0;
			seen_q  <= 1'b0;
			prev_q  <= 1'b0;
			fresh_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			act_q <= act_d;
			if (accept && fresh_q) begin
				rw_q    <= -glb_pkg::bear64(bearing);
				fb_q    <= bearing;
				lb_q    <= pos_q;
				cnt_q   <= '0;
				fresh_q <= 1'b0;
			end
			case (state_q)
				glb_pkg::S_DECIDE: begin
					if (!nl_q && !full && !ovf) begin
						rw_q  <= rw_q + glb_pkg::move_ext(mv_q);
						cnt_q <= cnt_q + CNT_W'(1);
						if (sp_q) begin
							seen_q <= 1'b1;
						end
					end
				end
				glb_pkg::S_EMIT: begin
					if (req_ready) begin
						seen_q <= 1'b0;
						case (act_q)
							glb_pkg::ACT_BEGIN: begin
								lb_q    <= pos_q;
								cnt_q   <= CNT_W'(1);
								fb_q    <= bear_q;
								rw_q    <= glb_pkg::move_ext(mv_q) - glb_pkg::bear64(bear_q);
								fresh_q <= 1'b0;
							end
							glb_pkg::ACT_WRAP: begin
								lb_q <= lb_q + INDEX_BITS'(s_q) + INDEX_BITS'(1);
							end
							default: begin
								lb_q    <= pos_q + INDEX_BITS'(1);
								cnt_q   <= '0;
								fresh_q <= 1'b1;
								rw_q    <= '0;
							end
						endcase
					end
				end
				glb_pkg::S_COPY_WR: begin
					if (k_q == '0) begin
						fb_q <= ram_rdata.bear;
					end
				end
				glb_pkg::S_TAIL: begin
					cnt_q <= keep_q + CNT_W'(1);
					fb_q  <= fb_tail;
					rw_q  <= glb_pkg::move_ext(mv_q) + suf_q - glb_pkg::bear64(fb_tail);
				end
				glb_pkg::S_FINISH: begin
					prev_q <= sp_q;
					pos_q  <= pos_q + INDEX_BITS'(1);
				end
				glb_pkg::S_LAST: begin
					if (req_ready) begin
						rw_q    <= '0;
						lb_q    <= '0;
						pos_q   <= '0;
						fb_q    <= '0;
						seen_q  <= 1'b0;
						prev_q  <= 1'b0;
						fresh_q <= 1'b1;
						cnt_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LINE_GLYPHS))
		else $error("line glyph count exceeds the line store");

	a_fresh_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> cnt_q == '0)
		else $error("fresh line holds glyphs");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == glb_pkg::S_DECIDE)
		else $error("accepted request not decided next cycle");

	a_scan_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glb_pkg::S_SCAN_RD) |-> (cnt_q != '0 && !nl_q))
		else $error("soft wrap scan on an empty line");

endmodule
